>>> design/mlws_pkg.sv
`timescale 1ns / 1ps

package mlws_pkg;

  localparam int TARGET_W = 26;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes on the configuration port.
  localparam int REG_TARGET_SUM = 0;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SUB,
    S_FINISH
  } state_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic full;
    logic qualify;
    logic last_item;
    logic out_busy;
  } status_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic ready;
    logic accept;
    logic store;
    logic hit;
    logic sub;
    logic emit;
  } ctrl_t;

endpackage

>>> design/mlws_addsub.sv
`timescale 1ns / 1ps

module mlws_addsub #(
  parameter int W = 27,
  parameter int BW = 16
) (
  input  logic [W-1:0]  a,
  input  logic [BW-1:0] b,
  input  logic          sub,
  output logic [W-1:0]  result
);

  logic [W-1:0] b_ext;

  assign b_ext = W'(b);
  assign result = sub ? (a - b_ext) : (a + b_ext);

endmodule

>>> design/mlws_mem.sv
`timescale 1ns / 1ps

module mlws_mem #(
  parameter int DEPTH = 1024,
  parameter int W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mlws_fsm.sv
`timescale 1ns / 1ps

module mlws_fsm (
  input  logic             clk,
  input  logic             rst,
  input  mlws_pkg::status_t status,
  output mlws_pkg::ctrl_t   ctrl
);

  import mlws_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (status.in_valid) begin
          state_next = status.full ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.qualify) begin
          state_next = S_SUB;
        end else if (status.last_item && status.out_busy) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUB: begin
        state_next = S_CHECK;
      end
      S_FINISH: begin
        if (!(status.last_item && status.out_busy)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE: begin
        ctrl.ready  = 1'b1;
        ctrl.accept = status.in_valid;
        ctrl.store  = status.in_valid && !status.full;
      end
      S_CHECK: begin
        ctrl.hit  = status.qualify;
        ctrl.emit = !status.qualify && status.last_item && !status.out_busy;
      end
      S_SUB: begin
        ctrl.sub = 1'b1;
      end
      S_FINISH: begin
        ctrl.emit = status.last_item && !status.out_busy;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  a_hit_then_sub: assert property (@(posedge clk) disable iff (rst)
    ctrl.hit |=> (state == S_SUB))
    else $error("drop not followed by subtract");

  a_sub_then_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |=> (state == S_CHECK))
    else $error("subtract not followed by check");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.accept, ctrl.hit, ctrl.sub, ctrl.emit}))
    else $error("conflicting datapath strobes");

endmodule

>>> design/min_length_window_sum_at_least.sv
`timescale 1ns / 1ps
// Flow: an item is accepted, then checked; each element that it drops from
//   the front of the window takes a memory read, then a subtract. No new
//   item is taken until the block is done with the last one, and each
//   element is dropped at most once. A last item also holds the input while
//   an earlier result still waits to be taken.
// Reset (synchronous, rst high) clears sequencer, pointers, count, sum, flags
//   and output valid, and sets target_sum to 1; window memory is not cleared.
module min_length_window_sum_at_least_core #(
  parameter int MAX_WINDOW = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input item channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [VALUE_BITS-1:0]                value,
  input  logic                                 last,
  // Result item channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_WINDOW+1)-1:0]      min_length,
  output logic                                 overflow,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mlws_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mlws_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mlws_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  import mlws_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  // Sum before shrinking stays below target + one value, so one spare bit.
  localparam int SUM_W = ((TARGET_W > VALUE_BITS) ? TARGET_W : VALUE_BITS) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WINDOW);

  // Configuration register
  logic [TARGET_W-1:0] target_sum;
  logic                reg_sel;
  logic                cfg_write;

  // Window state
  logic [PTR_W-1:0]    front_pointer;
  logic [PTR_W-1:0]    back_pointer;
  logic [CNT_W-1:0]    window_count;
  logic [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]    best_length;
  logic                best_found;
  logic                overflow_seen;
  logic                last_item;

  logic [SUM_W-1:0]      sum_next;
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] addend;

  status_t status;
  ctrl_t   ctrl;

  // ---------------------------------------------------------------------
  // APB register access: one register, target_sum, at byte address 0.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_TARGET_SUM));
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= TARGET_RESET;
    end else if (cfg_write) begin
      target_sum <= pwdata[TARGET_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(target_sum) : '0;

  // ---------------------------------------------------------------------
  // Sequencer: idle -> check -> (read front, subtract)* -> emit or idle.
  // ---------------------------------------------------------------------
  assign status.in_valid  = in_valid;
  assign status.full      = (window_count == CNT_FULL);
  assign status.qualify   = (window_count != '0) && (running_sum >= SUM_W'(target_sum));
  assign status.last_item = last_item;
  // Allow a waiting result to be replaced in the cycle it is taken.
  assign status.out_busy  = out_valid && !out_ready;

  mlws_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_ready = ctrl.ready;

  // ---------------------------------------------------------------------
  // Shared adder: add the incoming value when it is stored, subtract the
  // dropped front element in the subtract step.
  // ---------------------------------------------------------------------
  assign addend = ctrl.sub ? rd_data : value;

  mlws_addsub #(
    .W  (SUM_W),
    .BW (VALUE_BITS)
  ) u_addsub (
    .a      (running_sum),
    .b      (addend),
    .sub    (ctrl.sub),
    .result (sum_next)
  );

  // Window buffer: push at the back, read the front for each drop.
  mlws_mem #(
    .DEPTH (MAX_WINDOW),
    .W     (VALUE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ctrl.store),
    .wr_addr (back_pointer),
    .wr_data (value),
    .rd_en   (ctrl.hit),
    .rd_addr (front_pointer),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------
  // Window state update
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      front_pointer <= '0;
      back_pointer  <= '0;
      window_count  <= '0;
      running_sum   <= '0;
      best_found    <= 1'b0;
      overflow_seen <= 1'b0;
      last_item     <= 1'b0;
    end else if (ctrl.emit) begin
      // Clear for the next sequence.
      front_pointer <= '0;
      back_pointer  <= '0;
      window_count  <= '0;
      running_sum   <= '0;
      best_found    <= 1'b0;
      overflow_seen <= 1'b0;
      last_item     <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        last_item <= last;
        if (status.full) begin
          overflow_seen <= 1'b1;
        end
      end
      if (ctrl.store) begin
        back_pointer <= (back_pointer == PTR_LAST) ? '0 : back_pointer + 1'b1;
        window_count <= window_count + 1'b1;
        running_sum  <= sum_next;
      end
      if (ctrl.hit) begin
        best_found    <= 1'b1;
        front_pointer <= (front_pointer == PTR_LAST) ? '0 : front_pointer + 1'b1;
        window_count  <= window_count - 1'b1;
      end
      if (ctrl.sub) begin
        running_sum <= sum_next;
      end
    end
  end

  // Record the shortest qualifying length.
  always_ff @(posedge clk) begin
    if (ctrl.hit && (!best_found || (window_count < best_length))) begin
      best_length <= window_count;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: holds a result while the next item is accepted.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      min_length <= (best_found && !overflow_seen) ? best_length : '0;
      overflow   <= overflow_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_FULL)
    else $error("window count above buffer depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> (window_count == '0) && !overflow_seen && !best_found && out_valid)
    else $error("sequence state not cleared after result");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.hit |-> (window_count != '0))
    else $error("drop from an empty window");

endmodule

>>> tb/sv/window_len_checker.sv
`timescale 1ns / 1ps

module window_len_checker #(
  parameter int MAX_WINDOW = 1024,
  parameter int VALUE_BITS = 16,
  parameter int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [VALUE_BITS-1:0]           value,
  input  logic                            last,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [LEN_W-1:0]                min_length,
  input  logic                            overflow,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mlws_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mlws_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending
);

  import mlws_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = ((VALUE_BITS > TARGET_W) ? VALUE_BITS : TARGET_W) + 1;
  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = APB_ADDR_W'(4 * REG_TARGET_SUM);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
  } seq_result_t;

  seq_result_t           expected_results[$];
  logic [VALUE_BITS-1:0] window_mem[MAX_WINDOW];
  logic [PTR_W-1:0]      head_idx;
  logic [PTR_W-1:0]      tail_idx;
  logic [LEN_W-1:0]      fill;
  logic [LEN_W-1:0]      shortest;
  logic [SUM_W-1:0]      win_sum;
  logic [TARGET_W-1:0]   target;
  logic                  ovf_seen;
  int                    mismatches = 0;
  int                    waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] idx);
    return (idx == PTR_W'(MAX_WINDOW - 1)) ? '0 : idx + 1'b1;
  endfunction

  function void clear_window();
    head_idx = '0;
    tail_idx = '0;
    fill     = '0;
    win_sum  = '0;
    shortest = LEN_W'(MAX_WINDOW + 1);
    ovf_seen = 1'b0;
  endfunction

  // Push one element, shrink from the front while the sum still reaches the
  // target, and queue the sequence result on a last element.
  function void predict_window_step(input logic [VALUE_BITS-1:0] v, input logic is_last);
    seq_result_t res;
    if (fill == LEN_W'(MAX_WINDOW)) begin
      ovf_seen = 1'b1;
    end else begin
      window_mem[tail_idx] = v;
      tail_idx = wrap_inc(tail_idx);
      fill     = fill + 1'b1;
      win_sum  = win_sum + SUM_W'(v);
      while (fill != '0 && win_sum >= SUM_W'(target)) begin
        if (fill < shortest) shortest = fill;
        win_sum  = win_sum - SUM_W'(window_mem[head_idx]);
        head_idx = wrap_inc(head_idx);
        fill     = fill - 1'b1;
      end
    end
    if (is_last) begin
      res.len = (!ovf_seen && shortest <= LEN_W'(MAX_WINDOW)) ? shortest : '0;
      res.ovf = ovf_seen;
      expected_results.push_back(res);
      clear_window();
    end
  endfunction

  always @(posedge clk) begin : monitor
    seq_result_t want;
    if (rst) begin
      clear_window();
      target = TARGET_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TARGET)
        target = pwdata[TARGET_W-1:0];
      // Compare outgoing results before taking in a new item.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: min_length %0d overflow %0d",
                 min_length, overflow);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (min_length !== want.len) begin
            $error("min_length mismatch: expected %0d, actual %0d", want.len, min_length);
            mismatches++;
          end
          if (overflow !== want.ovf) begin
            $error("overflow mismatch: expected %0d, actual %0d", want.ovf, overflow);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_window_step(value, last);
    end
    waiting = expected_results.size();
  end

endmodule

>>> tb/sv/tb_min_length_window_sum_at_least_core.sv
`timescale 1ns / 1ps

module tb_min_length_window_sum_at_least_core;
  import mlws_pkg::*;

  localparam int MAX_WINDOW = 1024;
  localparam int VALUE_BITS = 16;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = APB_ADDR_W'(4 * REG_TARGET_SUM);
  localparam logic [TARGET_W-1:0]   TARGET_MAX  = '1;

  localparam int WATCHDOG_LIMIT = 20000; // idle cycles before giving up
  localparam int LONG_STALL     = 400;   // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES  = 16;    // quiet time after the last result
  localparam int PHASE_ITEMS    = 20;    // random items per target setting
  localparam int BURST_ITEMS    = 8;     // one-item sequences offered during the hold-off

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEN_W-1:0]      min_length;
  logic                  overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;
  bit                    stall_req = 1'b0; // ask the receiver for one long hold-off
  bit                    steady = 1'b0;    // no idling on either side while set
  logic [TARGET_W-1:0]   cur_target;

  always #4 clk = ~clk;

  min_length_window_sum_at_least_core #(
    .MAX_WINDOW(MAX_WINDOW),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_length(min_length),
    .overflow  (overflow),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // The checker mirrors the block from the channels and config writes, and
  // reports how many results are still owed and how many checks failed.
  window_len_checker #(
    .MAX_WINDOW(MAX_WINDOW),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_length(min_length),
    .overflow  (overflow),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Idle gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Element value: mix the extremes and full-range noise with values scaled
  // to the target, so windows of many lengths qualify.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int cap;
    cap = cur_target / 3 + 1;
    if (cap > 65535) cap = 65535;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VALUE_BITS'($urandom_range(0, 65535));
      default: return VALUE_BITS'($urandom_range(0, cap));
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic is_last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    value    = v;
    last     = is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every owed result has come out, then let the
  // block settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the target register with the block idle: setup, then access.
  task automatic write_target(input logic [TARGET_W-1:0] t);
    drain_results();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_TARGET;
    pwdata  = APB_DATA_W'(t);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    cur_target = t;
  endtask

  // Random sequences, mostly short and a few long; close the batch with last
  // so nothing is left half done.
  task automatic send_sequences(input int n_items);
    int sent;
    int seq_len;
    sent = 0;
    while (sent < n_items) begin
      seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 12);
      if (seq_len > n_items - sent) seq_len = n_items - sent;
      for (int i = 0; i < seq_len; i++) send_item(pick_value(), i == seq_len - 1);
      sent += seq_len;
    end
  endtask

  // Receiver: random ready pattern, one long hold-off on request.
  initial begin : receiver
    int gap_left;
    gap_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_req = 1'b0;
        out_ready = 1'b1;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  // Watchdog: any handshake on either channel or the config port restarts it.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_targets[8];
    phase_targets = '{7, 1, 250, 5000, 65535, 1000000, 0, TARGET_MAX};

    in_valid   = 1'b0;
    value      = '0;
    last       = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cur_target = TARGET_RESET;
    rst        = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Reset target of 1: any nonzero element qualifies alone.
    send_item(16'd1, 1'b1);
    send_item(16'hFFFF, 1'b1);

    // Zero target: every element, zero included, is a window of one.
    write_target('0);
    send_item(16'd0, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd5, 1'b1);

    // Largest target: short sequences never qualify.
    write_target(TARGET_MAX);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd0, 1'b1);

    // Exact hits, zero elements inside a window, and a miss.
    write_target(TARGET_W'(100));
    send_item(16'd0, 1'b0);
    send_item(16'd40, 1'b0);
    send_item(16'd60, 1'b1);
    send_item(16'd100, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd99, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd30, 1'b0);
    send_item(16'd30, 1'b0);
    send_item(16'd30, 1'b1);

    // Full-depth window: 1024 ones just reach the target, then keep sliding
    // past the buffer end so both pointers wrap. A zero then fills the
    // buffer, and the next elements find it full. Follow with a short
    // sequence to see the flag clear.
    write_target(TARGET_W'(MAX_WINDOW));
    for (int i = 0; i < MAX_WINDOW + 69; i++)
      send_item((i < MAX_WINDOW + 66) ? 16'd1 : 16'd0, i == MAX_WINDOW + 68);
    send_item(16'hFFFF, 1'b1);

    // Random part, one target setting per phase.
    for (int p = 0; p < 8; p++) begin
      if (p == 6) write_target(TARGET_W'($urandom_range(1, 67108863)));
      else write_target(TARGET_W'(phase_targets[p]));
      case (p)
        1: begin
          // Hold off the receiver and keep offering one-item sequences so
          // the result path backs up and stalls the input.
          stall_req = 1'b1;
          for (int i = 0; i < BURST_ITEMS; i++) send_item(pick_value(), 1'b1);
          send_sequences(PHASE_ITEMS - BURST_ITEMS);
        end
        2: begin
          steady = 1'b1;
          send_sequences(PHASE_ITEMS);
          steady = 1'b0;
        end
        3: begin
          // Pause the sender until every owed result is out.
          send_sequences(PHASE_ITEMS / 2);
          @(negedge clk);
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
          send_sequences(PHASE_ITEMS - PHASE_ITEMS / 2);
        end
        default: send_sequences(PHASE_ITEMS);
      endcase
    end

    drain_results();
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
